// ===== rtl/arf_pkg.sv =====
// ----------------------------------------------------------------------------
// arf_pkg
// Shared types, latencies and polynomial constants of the affine region frame.
// ----------------------------------------------------------------------------
package arf_pkg;

	localparam int SIN_LAT  = 7;
	localparam int SQRT_LAT = 32;
	localparam int DIVA_W   = 62;
	localparam int DIVB_W   = 64;
	localparam int DEN_W    = 32;

	localparam logic [31:0] POLY_C11 = 32'd3864;
	// Horner coefficients in order of use: C9, C7, C5, C3, C1
	localparam logic [4:0][31:0] POLY_COEF = {
		32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
	};

	typedef struct packed {
		logic signed [31:0] shape_xx;
		logic signed [31:0] shape_xy;
		logic signed [31:0] shape_yy;
		logic [15:0]        orient_angle;
		logic signed [31:0] centre_x;
		logic signed [31:0] centre_y;
		logic [15:0]        query_angle;
	} item_t;

	typedef struct packed {
		logic signed [31:0] frame_a00;
		logic signed [31:0] frame_a01;
		logic signed [31:0] frame_a10;
		logic signed [31:0] frame_a11;
		logic signed [31:0] frame_tx;
		logic signed [31:0] frame_ty;
		logic [31:0]        radius_out;
		logic               not_definite;
	} res_t;

endpackage

// ===== rtl/arf_delay.sv =====
// ----------------------------------------------------------------------------
// arf_delay
// Enabled shift line that carries side data along a pipeline.
// ----------------------------------------------------------------------------
module arf_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[N-1];

endmodule

// ===== rtl/arf_sine.sv =====
// ----------------------------------------------------------------------------
// arf_sine
// Pipelined quarter-wave sine, Q30 in, Q2.30 out, one Horner step per stage.
// ----------------------------------------------------------------------------
module arf_sine (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] x,
	output logic [31:0] s
);
	import arf_pkg::*;

	localparam int NH = 5;

	logic [61:0] sq_x;
	logic [30:0] x_s1;
	logic [31:0] y_s1;
	logic [30:0] hx_s   [NH];
	logic [31:0] hy_s   [NH-1];
	logic [31:0] hacc_s [NH];
	logic [62:0] out_prod;
	logic [31:0] s_s7;

	assign sq_x = 62'(x) * 62'(x);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x;
			y_s1 <= sq_x[61:30];
		end
	end

	for (genvar k = 0; k < NH; k++) begin : g_horner
		logic [30:0] xin;
		logic [31:0] yin;
		logic [31:0] ain;
		logic [63:0] prod;
		logic [63:0] step;

		if (k == 0) begin : g_first
			assign xin = x_s1;
			assign yin = y_s1;
			assign ain = POLY_C11;
		end else begin : g_next
			assign xin = hx_s[k-1];
			assign yin = hy_s[k-1];
			assign ain = hacc_s[k-1];
		end

		assign prod = 64'(yin) * 64'(ain);
		assign step = 64'(POLY_COEF[k]) - (prod >> 30);

		always_ff @(posedge clk) begin
			if (en) begin
				hx_s[k]   <= xin;
				hacc_s[k] <= step[31:0];
			end
		end

		if (k < NH - 1) begin : g_carry_y
			always_ff @(posedge clk) begin
				if (en) begin
					hy_s[k] <= yin;
				end
			end
		end
	end

	assign out_prod = 63'(hx_s[NH-1]) * 63'(hacc_s[NH-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			s_s7 <= out_prod[61:30];
		end
	end

	assign s = s_s7;

endmodule

// ===== rtl/arf_isqrt.sv =====
// ----------------------------------------------------------------------------
// arf_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module arf_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [31:0] r
);

	localparam int NS = 32;

	logic [63:0] rem_s  [NS];
	logic [63:0] root_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] rin;
		logic [63:0] oin;
		logic [63:0] trial;

		if (k == 0) begin : g_first
			assign rin = v;
			assign oin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign oin = root_s[k-1];
		end

		assign trial = oin + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rin >= trial) begin
					rem_s[k]  <= rin - trial;
					root_s[k] <= (oin >> 1) + BIT;
				end else begin
					rem_s[k]  <= rin;
					root_s[k] <= oin >> 1;
				end
			end
		end
	end

	assign r = root_s[NS-1][31:0];

endmodule

// ===== rtl/arf_div.sv =====
// ----------------------------------------------------------------------------
// arf_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module arf_div #(
	parameter int NW = 62,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] den_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW-1:0] rin;
		logic [NW-1:0] nin;
		logic [NW-1:0] qin;
		logic [DW-1:0] din;
		logic [DW:0]   part;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rin = '0;
			assign nin = num;
			assign qin = '0;
			assign din = den;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign nin = num_s[k-1];
			assign qin = quo_s[k-1];
			assign din = den_s[k-1];
		end

		assign part = {rin, nin[NW-1]};
		assign ge   = part >= {1'b0, din};
		assign diff = part - {1'b0, din};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : part[DW-1:0];
				num_s[k] <= nin << 1;
				quo_s[k] <= {qin[NW-2:0], ge};
				den_s[k] <= din;
			end
		end
	end

	assign quo = quo_s[NW-1];

endmodule

// ===== rtl/affine_region_frame_top.sv =====
// ----------------------------------------------------------------------------
// affine_region_frame_top
// Affine frame and directional radius of an oriented elliptic region.
//
//   channel  signals                         payload
//   item     item_valid / item_ready / item  arf_pkg::item_t
//   res      res_valid / res_ready / res     arf_pkg::res_t
//
// One transaction per cycle when not stalled; depth is mostly set by the two chained
// bit-per-stage dividers (62 and 64 stages) after the 32-stage square root.
// arst_n clears only the valid chain; the pipeline holds whole on a stall,
// which happens when a result waits and res_ready is low.
// ----------------------------------------------------------------------------
module affine_region_frame_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  arf_pkg::item_t item,
	output logic           res_valid,
	input  logic           res_ready,
	output arf_pkg::res_t  res
);
	import arf_pkg::*;

	localparam int PRE_LAT = SIN_LAT + 5;
	localparam int LAT     = PRE_LAT + SQRT_LAT + DIVA_W + DIVB_W + 1;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	localparam logic signed [64:0] RND65 = 65'sd536870912;
	localparam logic signed [67:0] RND68 = 68'sd536870912;

	typedef struct packed {
		logic signed [31:0] ct;
		logic signed [31:0] st;
		logic signed [34:0] v0;
		logic signed [34:0] v1;
		logic               nd;
		logic [31:0]        cx;
		logic [31:0]        cy;
	} c1_t;

	typedef struct packed {
		logic        sct;
		logic        sst;
		logic        sv0;
		logic        sv1;
		logic [31:0] sd;
		logic        nd;
		logic [31:0] cx;
		logic [31:0] cy;
	} c2_t;

	typedef struct packed {
		logic              sct;
		logic              sst;
		logic              sv0;
		logic              sv1;
		logic              nd;
		logic [31:0]       cx;
		logic [31:0]       cy;
		logic [DIVA_W-1:0] q0;
		logic [DIVA_W-1:0] q2;
		logic [DIVA_W-1:0] qr;
	} c3_t;

	function automatic logic [63:0] quad_trig(input logic [1:0] quad,
			input logic [31:0] sa, input logic [31:0] sb);
		logic [31:0] cs;
		logic [31:0] sn;
		unique case (quad)
			QUAD_I:   begin sn = sb;       cs = sb; sn = sa;   end
			QUAD_II:  begin sn = sb;       cs = 32'(-sa);      end
			QUAD_III: begin sn = 32'(-sa); cs = 32'(-sb);      end
			QUAD_IV:  begin sn = 32'(-sb); cs = sa;            end
		endcase
		return {cs, sn};
	endfunction

	function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] mag);
		logic [63:0] neg_mag;
		neg_mag = 64'd0 - mag;
		if (!neg) begin
			return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return (mag > 64'h8000_0000) ? 32'h8000_0000 : neg_mag[31:0];
	endfunction

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en         = !vld_q[LAT-1] || res_ready;
	assign item_ready = en;
	assign res_valid  = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	// trig
	logic [30:0] fo, fo_c, fq, fq_c;
	logic [31:0] sa_o, sb_o, sa_q, sb_q;
	item_t       item_d;

	assign fo   = {1'b0, item.orient_angle[13:0], 16'd0};
	assign fo_c = 31'h4000_0000 - fo;
	assign fq   = {1'b0, item.query_angle[13:0], 16'd0};
	assign fq_c = 31'h4000_0000 - fq;

	arf_sine u_sin_oa (.clk(clk), .en(en), .x(fo),   .s(sa_o));
	arf_sine u_sin_ob (.clk(clk), .en(en), .x(fo_c), .s(sb_o));
	arf_sine u_sin_qa (.clk(clk), .en(en), .x(fq),   .s(sa_q));
	arf_sine u_sin_qb (.clk(clk), .en(en), .x(fq_c), .s(sb_q));

	arf_delay #(.W($bits(item_t)), .N(SIN_LAT)) u_dly_item (
		.clk(clk), .en(en), .d(item), .q(item_d)
	);

	// s8: quadrant fold
	logic [63:0]        trig_o, trig_q;
	logic signed [31:0] ct_s8, st_s8, cq_s8, sq_s8, a_s8, b_s8, c_s8;
	logic [31:0]        cx_s8, cy_s8;

	assign trig_o = quad_trig(item_d.orient_angle[15:14], sa_o, sb_o);
	assign trig_q = quad_trig(item_d.query_angle[15:14], sa_q, sb_q);

	always_ff @(posedge clk) begin
		if (en) begin
			ct_s8 <= trig_o[63:32];
			st_s8 <= trig_o[31:0];
			cq_s8 <= trig_q[63:32];
			sq_s8 <= trig_q[31:0];
			a_s8  <= item_d.shape_xx;
			b_s8  <= item_d.shape_xy;
			c_s8  <= item_d.shape_yy;
			cx_s8 <= item_d.centre_x;
			cy_s8 <= item_d.centre_y;
		end
	end

	// s9: first products
	logic signed [63:0] pa_ct_s9, pb_st_s9, pb_ct_s9, pc_st_s9;
	logic signed [63:0] pc_cq_s9, pb_sq_s9, pa_sq_s9, pb_cq_s9, ac_s9, bb_s9;
	logic signed [31:0] ct_s9, st_s9, cq_s9, sq_s9;
	logic               a_pos_s9;
	logic [31:0]        cx_s9, cy_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_ct_s9 <= 64'(a_s8) * 64'(ct_s8);
			pb_st_s9 <= 64'(b_s8) * 64'(st_s8);
			pb_ct_s9 <= 64'(b_s8) * 64'(ct_s8);
			pc_st_s9 <= 64'(c_s8) * 64'(st_s8);
			pc_cq_s9 <= 64'(c_s8) * 64'(cq_s8);
			pb_sq_s9 <= 64'(b_s8) * 64'(sq_s8);
			pa_sq_s9 <= 64'(a_s8) * 64'(sq_s8);
			pb_cq_s9 <= 64'(b_s8) * 64'(cq_s8);
			ac_s9    <= 64'(a_s8) * 64'(c_s8);
			bb_s9    <= 64'(b_s8) * 64'(b_s8);
			ct_s9    <= ct_s8;
			st_s9    <= st_s8;
			cq_s9    <= cq_s8;
			sq_s9    <= sq_s8;
			a_pos_s9 <= !a_s8[31] && (a_s8 != 32'sd0);
			cx_s9    <= cx_s8;
			cy_s9    <= cy_s8;
		end
	end

	// s10: round v and w, determinant
	logic signed [64:0] v0_sum, v1_sum, w0_sum, w1_sum, det_c;
	logic signed [34:0] v0_s10, v1_s10, w0_s10, w1_s10;
	logic signed [31:0] ct_s10, st_s10, cq_s10, sq_s10;
	logic [63:0]        det_s10;
	logic               nd_s10;
	logic [31:0]        cx_s10, cy_s10;

	assign v0_sum = 65'(pa_ct_s9) + 65'(pb_st_s9) + RND65;
	assign v1_sum = 65'(pb_ct_s9) + 65'(pc_st_s9) + RND65;
	assign w0_sum = 65'(pc_cq_s9) - 65'(pb_sq_s9) + RND65;
	assign w1_sum = 65'(pa_sq_s9) - 65'(pb_cq_s9) + RND65;
	assign det_c  = 65'(ac_s9) - 65'(bb_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			v0_s10  <= v0_sum[64:30];
			v1_s10  <= v1_sum[64:30];
			w0_s10  <= w0_sum[64:30];
			w1_s10  <= w1_sum[64:30];
			det_s10 <= det_c[63:0];
			nd_s10  <= !a_pos_s9 || det_c[64] || (det_c == 65'sd0);
			ct_s10  <= ct_s9;
			st_s10  <= st_s9;
			cq_s10  <= cq_s9;
			sq_s10  <= sq_s9;
			cx_s10  <= cx_s9;
			cy_s10  <= cy_s9;
		end
	end

	// s11: quadratic form products
	logic signed [66:0] pp0_s11, pp1_s11, pn0_s11, pn1_s11;
	logic signed [31:0] ct_s11, st_s11;
	logic signed [34:0] v0_s11, v1_s11;
	logic [63:0]        det_s11;
	logic               nd_s11;
	logic [31:0]        cx_s11, cy_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			pp0_s11 <= 67'(ct_s10) * 67'(v0_s10);
			pp1_s11 <= 67'(st_s10) * 67'(v1_s10);
			pn0_s11 <= 67'(cq_s10) * 67'(w0_s10);
			pn1_s11 <= 67'(sq_s10) * 67'(w1_s10);
			ct_s11  <= ct_s10;
			st_s11  <= st_s10;
			v0_s11  <= v0_s10;
			v1_s11  <= v1_s10;
			det_s11 <= det_s10;
			nd_s11  <= nd_s10;
			cx_s11  <= cx_s10;
			cy_s11  <= cy_s10;
		end
	end

	// s12: round and clamp p and n
	logic signed [67:0] p_sum, n_sum;
	logic [37:0]        p_c, n_c;
	logic [63:0]        sp_in_s12, sn_in_s12, det_s12;
	c1_t                c1_s12, c1_d;

	assign p_sum = 68'(pp0_s11) + 68'(pp1_s11) + RND68;
	assign n_sum = 68'(pn0_s11) + 68'(pn1_s11) + RND68;

	always_comb begin
		p_c = p_sum[67:30];
		if (p_sum[67] || (p_c == 38'd0)) begin
			p_c = 38'd1;
		end
		n_c = n_sum[67] ? 38'd0 : n_sum[67:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_in_s12 <= {p_c[33:0], 30'd0};
			sn_in_s12 <= {n_c[33:0], 30'd0};
			det_s12   <= det_s11;
			c1_s12    <= '{ct: ct_s11, st: st_s11, v0: v0_s11, v1: v1_s11,
				nd: nd_s11, cx: cx_s11, cy: cy_s11};
		end
	end

	// square roots
	logic [31:0] sp, sn, sd;

	arf_isqrt u_sqrt_p (.clk(clk), .en(en), .v(sp_in_s12), .r(sp));
	arf_isqrt u_sqrt_n (.clk(clk), .en(en), .v(sn_in_s12), .r(sn));
	arf_isqrt u_sqrt_d (.clk(clk), .en(en), .v(det_s12),   .r(sd));

	arf_delay #(.W($bits(c1_t)), .N(SQRT_LAT)) u_dly_c1 (
		.clk(clk), .en(en), .d(c1_s12), .q(c1_d)
	);

	// first divisions
	logic [31:0]       mag_ct, mag_st;
	logic [34:0]       mag_v0, mag_v1;
	logic [DIVA_W-1:0] na0, na1, na2, na3, nar;
	logic [DIVA_W-1:0] qa0, qa1, qa2, qa3, qar;
	c2_t               c2_in, c2_d;

	assign mag_ct = c1_d.ct[31] ? 32'd0 - c1_d.ct : c1_d.ct;
	assign mag_st = c1_d.st[31] ? 32'd0 - c1_d.st : c1_d.st;
	assign mag_v0 = c1_d.v0[34] ? 35'd0 - c1_d.v0 : c1_d.v0;
	assign mag_v1 = c1_d.v1[34] ? 35'd0 - c1_d.v1 : c1_d.v1;

	assign na0 = DIVA_W'({mag_ct, 13'd0});
	assign na1 = DIVA_W'({mag_st, 13'd0});
	assign na2 = DIVA_W'({mag_v0, 27'd0});
	assign na3 = DIVA_W'({mag_v1, 27'd0});
	assign nar = DIVA_W'({sn, 13'd0});

	assign c2_in = '{sct: c1_d.ct[31], sst: c1_d.st[31], sv0: c1_d.v0[34],
		sv1: c1_d.v1[34], sd: sd, nd: c1_d.nd, cx: c1_d.cx, cy: c1_d.cy};

	arf_div #(.NW(DIVA_W), .DW(DEN_W)) u_div_a0 (.clk(clk), .en(en), .num(na0), .den(sp), .quo(qa0));
	arf_div #(.NW(DIVA_W), .DW(DEN_W)) u_div_a1 (.clk(clk), .en(en), .num(na1), .den(sp), .quo(qa1));
	arf_div #(.NW(DIVA_W), .DW(DEN_W)) u_div_a2 (.clk(clk), .en(en), .num(na2), .den(sp), .quo(qa2));
	arf_div #(.NW(DIVA_W), .DW(DEN_W)) u_div_a3 (.clk(clk), .en(en), .num(na3), .den(sp), .quo(qa3));
	arf_div #(.NW(DIVA_W), .DW(DEN_W)) u_div_ar (.clk(clk), .en(en), .num(nar), .den(sd), .quo(qar));

	arf_delay #(.W($bits(c2_t)), .N(DIVA_W)) u_dly_c2 (
		.clk(clk), .en(en), .d(c2_in), .q(c2_d)
	);

	// second divisions
	logic [DIVB_W-1:0] nb0, nb1, qb0, qb1;
	c3_t               c3_in, c3_d;

	assign nb0 = {qa2[47:0], 16'd0};
	assign nb1 = {qa3[47:0], 16'd0};

	assign c3_in = '{sct: c2_d.sct, sst: c2_d.sst, sv0: c2_d.sv0, sv1: c2_d.sv1,
		nd: c2_d.nd, cx: c2_d.cx, cy: c2_d.cy, q0: qa0, q2: qa1, qr: qar};

	arf_div #(.NW(DIVB_W), .DW(DEN_W)) u_div_b0 (.clk(clk), .en(en), .num(nb0), .den(c2_d.sd), .quo(qb0));
	arf_div #(.NW(DIVB_W), .DW(DEN_W)) u_div_b1 (.clk(clk), .en(en), .num(nb1), .den(c2_d.sd), .quo(qb1));

	arf_delay #(.W($bits(c3_t)), .N(DIVB_W)) u_dly_c3 (
		.clk(clk), .en(en), .d(c3_in), .q(c3_d)
	);

	// saturate and drop a non-definite region
	res_t res_c, res_q;

	always_comb begin
		res_c = '0;
		if (c3_d.nd) begin
			res_c.not_definite = 1'b1;
		end else begin
			res_c.frame_a00  = sat_s32(c3_d.sct, 64'(c3_d.q0));
			res_c.frame_a10  = sat_s32(c3_d.sst, 64'(c3_d.q2));
			res_c.frame_a01  = sat_s32(!c3_d.sv1, qb1);
			res_c.frame_a11  = sat_s32(c3_d.sv0, qb0);
			res_c.frame_tx   = c3_d.cx;
			res_c.frame_ty   = c3_d.cy;
			res_c.radius_out = (c3_d.qr > DIVA_W'(64'hFFFF_FFFF)) ?
				32'hFFFF_FFFF : c3_d.qr[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
		end
	end

	assign res = res_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |=> vld_q == $past(vld_q))
		else $error("valid chain moved during a stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> vld_q[0])
		else $error("accepted transaction lost at pipeline entry");

	a_nd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.not_definite |-> res.radius_out == 32'd0 &&
		res.frame_a00 == 32'sd0 && res.frame_tx == 32'sd0 && res.frame_ty == 32'sd0)
		else $error("non-definite result carries data");

endmodule

// ===== tb/sv/arf_checker.sv =====
// ----------------------------------------------------------------------------
// arf_checker
// Watches both channels of the affine region frame, predicts every result
// from the accepted input transaction and compares it field by field in order.
// ----------------------------------------------------------------------------
module arf_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_ready,
	input  arf_pkg::item_t item,
	input  logic           res_valid,
	input  logic           res_ready,
	input  arf_pkg::res_t  res,
	output int             errors,
	output int             pending
);
	import arf_pkg::*;

	res_t frames_due[$];

	function automatic longint round30(longint x);
		longint y;
		y = x + (64'sd1 <<< 29);
		return y >>> 30;
	endfunction

	function automatic longint floor_sqrt(bit [63:0] v);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint quarter_sin(bit [63:0] x);
		bit [63:0] y, acc;
		y = (x * x) >> 30;
		acc = 64'(POLY_C11);
		for (int i = 0; i < 5; i++) acc = 64'(POLY_COEF[i]) - ((y * acc) >> 30);
		return longint'((x * acc) >> 30);
	endfunction

	function automatic void sin_cos(logic [15:0] ang, output longint cs, output longint sn);
		bit [63:0] f;
		longint sa, sb;
		f = 64'(ang[13:0]) << 16;
		sa = quarter_sin(f);
		sb = quarter_sin((64'd1 << 30) - f);
		case (ang[15:14])
			2'd0: begin sn = sa; cs = sb; end
			2'd1: begin sn = sb; cs = -sa; end
			2'd2: begin sn = -sa; cs = -sb; end
			default: begin sn = -sb; cs = sa; end
		endcase
	endfunction

	function automatic logic [31:0] clip_s32(longint x);
		if (x > 64'sd2147483647) x = 64'sd2147483647;
		if (x < -64'sd2147483648) x = -64'sd2147483648;
		return x[31:0];
	endfunction

	function automatic res_t region_frame(item_t it);
		res_t o;
		longint a, b, c, det, ct, st, cq, sq, v0, v1, p, sp, sd, t0, t1, w0, w1, n, sn, r;
		o = '0;
		a = it.shape_xx;
		b = it.shape_xy;
		c = it.shape_yy;
		det = a * c - b * b;
		if (a <= 0 || det <= 0) begin
			o.not_definite = 1'b1;
			return o;
		end
		sin_cos(it.orient_angle, ct, st);
		v0 = round30(a * ct + b * st);
		v1 = round30(b * ct + c * st);
		p = round30(ct * v0 + st * v1);
		if (p < 1) p = 1;
		sp = floor_sqrt(64'(p) << 30);
		sd = floor_sqrt(64'(det));
		t0 = (v0 * (64'sd1 <<< 27)) / sp;
		t1 = (v1 * (64'sd1 <<< 27)) / sp;
		o.frame_a00 = clip_s32((ct * 8192) / sp);
		o.frame_a01 = clip_s32(-((t1 * 65536) / sd));
		o.frame_a10 = clip_s32((st * 8192) / sp);
		o.frame_a11 = clip_s32((t0 * 65536) / sd);
		o.frame_tx = it.centre_x;
		o.frame_ty = it.centre_y;
		sin_cos(it.query_angle, cq, sq);
		w0 = round30(c * cq - b * sq);
		w1 = round30(a * sq - b * cq);
		n = round30(cq * w0 + sq * w1);
		if (n < 0) n = 0;
		sn = floor_sqrt(64'(n) << 30);
		r = (sn * 8192) / sd;
		if (r > 64'sd4294967295) r = 64'sd4294967295;
		o.radius_out = r[31:0];
		return o;
	endfunction

	initial errors = 0;
	assign pending = frames_due.size();

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (item_valid && item_ready) frames_due.push_back(region_frame(item));
			if (res_valid && res_ready) begin
				if (frames_due.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result transaction %h", res);
				end else begin
					want = frames_due.pop_front();
					if (res !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch a00 %h/%h a01 %h/%h a10 %h/%h a11 %h/%h",
								want.frame_a00, res.frame_a00, want.frame_a01, res.frame_a01,
								want.frame_a10, res.frame_a10, want.frame_a11, res.frame_a11);
							$display("  tx %h/%h ty %h/%h radius %h/%h nd %b/%b",
								want.frame_tx, res.frame_tx, want.frame_ty, res.frame_ty,
								want.radius_out, res.radius_out,
								want.not_definite, res.not_definite);
						end
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives directed and random elliptic regions into the affine region frame
// under varied idling and a long output hold-off; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
	import arf_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  item_valid;
	logic  item_ready;
	item_t item;
	logic  res_valid;
	logic  res_ready;
	res_t  res;
	int    errors;
	int    pending;
	int    idle_pct;
	int    stall_pct;
	int    hold_req;
	int    cycles;

	affine_region_frame_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	arf_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_region(item_t it);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	function automatic item_t rand_region();
		item_t it;
		logic [31:0] lim;
		it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(99) < 85) begin
			it.shape_xx = ($urandom >> $urandom_range(1, 31)) + 1;
			it.shape_yy = ($urandom >> $urandom_range(1, 31)) + 1;
			lim = (it.shape_xx < it.shape_yy) ? it.shape_xx : it.shape_yy;
			it.shape_xy = $signed($urandom % lim) * ($urandom_range(1) ? 1 : -1);
		end
		return it;
	endfunction

	function automatic item_t make_region(int xx, int xy, int yy, int ot, int qa);
		item_t it;
		it.shape_xx = xx;
		it.shape_xy = xy;
		it.shape_yy = yy;
		it.orient_angle = 16'(ot);
		it.query_angle = 16'(qa);
		it.centre_x = $urandom;
		it.centre_y = $urandom;
		return it;
	endfunction

	initial begin
		item_t it;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes, quadrants, non-definite and clamping cases
		send_region(make_region(32'h7fffffff, 0, 32'h7fffffff, 0, 0));
		send_region(make_region(1, 0, 1, 16'h4000, 16'h8000));
		send_region(make_region(1, 0, 32'h7fffffff, 16'h8000, 16'h4000));
		send_region(make_region(32'h7fffffff, 32'h7ffffffe, 32'h7fffffff, 16'hc000, 16'hffff));
		send_region(make_region(0, 0, 5, 0, 0));
		send_region(make_region(32'h80000000, 0, 32'h80000000, 0, 0));
		send_region(make_region(100, 100, 100, 16'h1234, 16'h2000));
		send_region(make_region(100, 200, 100, 16'h2000, 0));
		send_region(make_region(5, 32'h80000000, 5, 0, 0));
		send_region(make_region(1 << 24, 0, 1 << 24, 16'hffff, 16'hffff));
		send_region(make_region(2, -1, 1, 16'h6000, 16'ha000));
		send_region(make_region(3, 1, 1, 16'he000, 16'h6000));
		send_region(make_region(1 << 24, 1 << 23, 1 << 22, 16'h0001, 16'h7fff));
		it = make_region(1 << 24, 0, 1 << 24, 0, 0);
		it.centre_x = 32'h7fffffff;
		it.centre_y = 32'h80000000;
		send_region(it);
		it.centre_x = 32'h80000000;
		it.centre_y = 32'h7fffffff;
		send_region(it);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 28) : 0;
			stall_pct = (ph == 2) ? 81 : (ph == 3 ? 28 : 0);
			for (int i = 0; i < 450; i++) begin
				if (ph == 0 && i == 50) hold_req = 600;
				send_region(rand_region());
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/arf_pkg.sv
rtl/arf_delay.sv
rtl/arf_sine.sv
rtl/arf_isqrt.sv
rtl/arf_div.sv
rtl/affine_region_frame_top.sv
tb/sv/arf_checker.sv
tb/sv/tb.sv
